### hdl/dvc_pkg.sv
// Shared types and constants for the distinct value counter.
// No dependencies; imported by dvc_store, dvc_ctrl and the top level.
`timescale 1ns / 1ps

package dvc_pkg;

	localparam int VALUE_W = 64;
	localparam int COUNT_W = 16;

	// occurrence counts stop here
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// one table entry: a distinct value and its count
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
	} entry_t;

	// write request from the sequencer to the table memory
	typedef struct packed {
		logic   en;
		entry_t data;
	} wr_req_t;

endpackage

### hdl/distinct_value_counter.sv
// Top level of the distinct value counter: sequencer plus table memory.
// Depends on dvc_pkg, dvc_store and dvc_ctrl.
`timescale 1ns / 1ps

// Counts distinct 64-bit patterns in a batch, keeping up to MAX_DISTINCT
// entries in order of first appearance, each with a count saturating at
// 65535. Each value is checked against the table one entry per cycle by a
// single comparator behind the registered memory read port, and in_stall
// stays high until the item is counted and any streaming of the table
// is done. On the item marked batch_end the table is streamed out as
// value/count pairs, each read from memory and then loaded into the output
// register when no output stall holds it, the last pair flagged by
// final_pair; table_overflowed is the same on every pair of a batch and
// tells that a new value was dropped for lack of room. The table is then
// empty for the next batch. The memory needs no clearing after reset.
module distinct_value_counter
	import dvc_pkg::*;
#(
	parameter int MAX_DISTINCT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [VALUE_W-1:0] sample_bits,
	input  logic               batch_end,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [VALUE_W-1:0] distinct_bits,
	output logic [COUNT_W-1:0] occurrences,
	output logic               final_pair,
	output logic               table_overflowed
);

	localparam int IDX_W = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;

	wr_req_t          wr;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_data;

	dvc_ctrl #(
		.MAX_DISTINCT(MAX_DISTINCT)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.sample_bits     (sample_bits),
		.batch_end       (batch_end),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.distinct_bits   (distinct_bits),
		.occurrences     (occurrences),
		.final_pair      (final_pair),
		.table_overflowed(table_overflowed),
		.wr              (wr),
		.wr_addr         (wr_addr),
		.rd_addr         (rd_addr),
		.rd_data         (rd_data)
	);

	dvc_store #(
		.DEPTH(MAX_DISTINCT)
	) u_store (
		.clk    (clk),
		.wr     (wr),
		.wr_addr(wr_addr),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule

### hdl/dvc_store.sv
// Table memory: one write port, one registered read port.
// Depends on dvc_pkg for entry_t and wr_req_t.
`timescale 1ns / 1ps

module dvc_store
	import dvc_pkg::*;
#(
	parameter int DEPTH = 64,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  wr_req_t          wr,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data
);

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr_addr] <= wr.data;
		end
	end

	// registered read, every cycle
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/dvc_ctrl.sv
// Sequencer: scans the table with one shared comparator, updates or
// appends entries, and streams the table out on batch end.
// Depends on dvc_pkg; drives the dvc_store ports.
`timescale 1ns / 1ps

module dvc_ctrl
	import dvc_pkg::*;
#(
	parameter int MAX_DISTINCT = 64,
	localparam int IDX_W = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1,
	localparam int CNT_W = $clog2(MAX_DISTINCT + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [VALUE_W-1:0] sample_bits,
	input  logic               batch_end,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [VALUE_W-1:0] distinct_bits,
	output logic [COUNT_W-1:0] occurrences,
	output logic               final_pair,
	output logic               table_overflowed,
	// table memory
	output wr_req_t            wr,
	output logic [IDX_W-1:0]   wr_addr,
	output logic [IDX_W-1:0]   rd_addr,
	input  entry_t             rd_data
);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_SCAN      = 3'd1;
	localparam logic [2:0] ST_INSERT    = 3'd2;
	localparam logic [2:0] ST_EMIT_RD   = 3'd3;
	localparam logic [2:0] ST_EMIT_WAIT = 3'd4;

	localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(MAX_DISTINCT);

	logic [2:0]         state_q;
	logic [VALUE_W-1:0] sample_q;
	logic               last_q;
	logic [CNT_W-1:0]   used_q;
	logic               overflow_q;
	logic [CNT_W-1:0]   ptr_q;     // next entry to read
	logic [IDX_W-1:0]   chk_q;     // entry now in rd_data
	logic               chk_valid_q;
	logic [IDX_W-1:0]   emit_q;

	logic               out_valid_q;
	logic [VALUE_W-1:0] out_bits_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_final_q;
	logic               out_ovf_q;

	logic               in_xfer;
	logic               hit;
	logic               chk_is_last;
	logic               emit_is_last;
	logic               out_load;
	logic [COUNT_W-1:0] bumped;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;

	// shared comparator and count bump
	assign hit          = chk_valid_q && (rd_data.value == sample_q);
	assign chk_is_last  = (CNT_W'(chk_q) + 1'b1) == used_q;
	assign emit_is_last = (CNT_W'(emit_q) + 1'b1) == used_q;
	assign bumped       = (rd_data.count == COUNT_MAX) ? rd_data.count
	                                                   : rd_data.count + 1'b1;
	assign out_load     = (state_q == ST_EMIT_WAIT) && (!out_valid_q || !out_stall);

	// read address: emit pointer during emission, scan pointer otherwise
	always_comb begin
		if (state_q == ST_EMIT_RD || state_q == ST_EMIT_WAIT) begin
			rd_addr = emit_q;
		end else begin
			rd_addr = ptr_q[IDX_W-1:0];
		end
	end

	// table writes: count update on a hit, append on insert
	always_comb begin
		wr.en         = 1'b0;
		wr.data.value = sample_q;
		wr.data.count = COUNT_W'(1);
		wr_addr       = used_q[IDX_W-1:0];
		if (state_q == ST_SCAN && hit) begin
			wr.en         = 1'b1;
			wr.data.count = bumped;
			wr_addr       = chk_q;
		end else if (state_q == ST_INSERT && used_q < CAPACITY) begin
			wr.en = 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			overflow_q  <= 1'b0;
			ptr_q       <= '0;
			chk_valid_q <= 1'b0;
			emit_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						ptr_q       <= '0;
						chk_valid_q <= 1'b0;
						state_q     <= (used_q == '0) ? ST_INSERT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					chk_valid_q <= (ptr_q < used_q);
					if (ptr_q < used_q) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (hit) begin
						emit_q  <= '0;
						state_q <= last_q ? ST_EMIT_RD : ST_IDLE;
					end else if (chk_valid_q && chk_is_last) begin
						state_q <= ST_INSERT;
					end
				end
				ST_INSERT: begin
					if (used_q < CAPACITY) begin
						used_q <= used_q + 1'b1;
					end else begin
						overflow_q <= 1'b1;
					end
					emit_q  <= '0;
					state_q <= last_q ? ST_EMIT_RD : ST_IDLE;
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WAIT;
				end
				ST_EMIT_WAIT: begin
					if (out_load) begin
						if (emit_is_last) begin
							used_q     <= '0;
							overflow_q <= 1'b0;
							state_q    <= ST_IDLE;
						end else begin
							emit_q  <= emit_q + 1'b1;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan index of the entry arriving from the read port
	always_ff @(posedge clk) begin
		chk_q <= ptr_q[IDX_W-1:0];
	end

	// captured input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q <= sample_bits;
			last_q   <= batch_end;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_bits_q  <= rd_data.value;
			out_count_q <= rd_data.count;
			out_final_q <= emit_is_last;
			out_ovf_q   <= overflow_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign distinct_bits    = out_bits_q;
	assign occurrences      = out_count_q;
	assign final_pair       = out_final_q;
	assign table_overflowed = out_ovf_q;

	// checks
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CAPACITY)
		else $error("table fill beyond capacity");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && emit_is_last) |=> (used_q == '0 && !overflow_q))
		else $error("table not cleared after last pair");

	a_wr_states: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == ST_SCAN || state_q == ST_INSERT))
		else $error("table write outside tally");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && hit) |-> (CNT_W'(chk_q) < used_q))
		else $error("match on an unused entry");

endmodule
